FILE: rtl/ptz_pkg.sv
// Shared types, request codes and speed tables for the PTZ dome command framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptz_pkg;

  localparam int FRAME_LEN  = 8;
  localparam int BYTE_W     = 8;
  localparam int REQ_W      = 5;
  localparam int CNT_W      = $clog2(FRAME_LEN);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0] START_CODE = 8'hE5;
  localparam logic [7:0] DEVICE_ID  = 8'h01;

  // Command byte values
  localparam logic [7:0] CMD_ZOOM_WIDE  = 8'h04;
  localparam logic [7:0] CMD_ZOOM_TELE  = 8'h08;
  localparam logic [7:0] CMD_IRIS_OPEN  = 8'h04;
  localparam logic [7:0] CMD_IRIS_CLOSE = 8'h02;
  localparam logic [7:0] CMD_FOCUS_NEAR = 8'h02;
  localparam logic [7:0] CMD_FOCUS_FAR  = 8'h01;
  localparam logic [7:0] CMD_SET_PRESET = 8'hA1;
  localparam logic [7:0] CMD_GOTO_PRESET = 8'hA4;
  localparam logic [7:0] PRESET_MARK    = 8'hFF;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PAN_LEFT     = 5'd0;
  localparam logic [REQ_W-1:0] REQ_PAN_RIGHT    = 5'd1;
  localparam logic [REQ_W-1:0] REQ_TILT_UP      = 5'd2;
  localparam logic [REQ_W-1:0] REQ_TILT_DOWN    = 5'd3;
  localparam logic [REQ_W-1:0] REQ_LEFT_UP      = 5'd4;
  localparam logic [REQ_W-1:0] REQ_LEFT_DOWN    = 5'd5;
  localparam logic [REQ_W-1:0] REQ_RIGHT_UP     = 5'd6;
  localparam logic [REQ_W-1:0] REQ_RIGHT_DOWN   = 5'd7;
  localparam logic [REQ_W-1:0] REQ_ZOOM_WIDE    = 5'd8;
  localparam logic [REQ_W-1:0] REQ_ZOOM_TELE    = 5'd9;
  localparam logic [REQ_W-1:0] REQ_IRIS_OPEN    = 5'd10;
  localparam logic [REQ_W-1:0] REQ_IRIS_CLOSE   = 5'd11;
  localparam logic [REQ_W-1:0] REQ_FOCUS_NEAR   = 5'd12;
  localparam logic [REQ_W-1:0] REQ_FOCUS_FAR    = 5'd13;
  localparam logic [REQ_W-1:0] REQ_STOP         = 5'd14;
  localparam logic [REQ_W-1:0] REQ_SET_PRESET   = 5'd15;
  localparam logic [REQ_W-1:0] REQ_CLEAR_PRESET = 5'd16;
  localparam logic [REQ_W-1:0] REQ_GOTO_PRESET  = 5'd17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ZOOM   = 2'd2;

  localparam logic [7:0] RST_CAMERA_ADDRESS = 8'd1;
  localparam logic [7:0] RST_DEFAULT_PT     = 8'd50;
  localparam logic [7:0] RST_DEFAULT_ZOOM   = 8'd50;

  typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_bytes_t;

  // Built frame plus a flag that says whether the request yields one
  typedef struct packed {
    logic         emit;
    frame_bytes_t bytes;
  } frame_t;

  typedef struct packed {
    logic [7:0] camera_address;
    logic [7:0] default_pt;
    logic [7:0] default_zoom;
  } cfg_t;

  // Table index setting/10 - 1, clamped to 0..9, by threshold compares
  function automatic logic [3:0] speed_index(input logic [7:0] setting);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (setting >= 8'(10 * k + 10)) idx = 4'(k);
    end
    return idx;
  endfunction

  function automatic logic [7:0] pt_speed(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h0C;
      4'd1:    v = 8'h18;
      4'd2:    v = 8'h20;
      4'd3:    v = 8'h2C;
      4'd4:    v = 8'h38;
      4'd5:    v = 8'h44;
      4'd6:    v = 8'h52;
      4'd7:    v = 8'h60;
      4'd8:    v = 8'h6F;
      default: v = 8'h7F;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] zoom_level(input logic [3:0] idx);
    logic [2:0] v;
    case (idx)
      4'd0:             v = 3'd0;
      4'd1, 4'd2:       v = 3'd1;
      4'd3, 4'd4, 4'd5: v = 3'd2;
      4'd6, 4'd7:       v = 3'd3;
      default:          v = 3'd4;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pt_dir_code(input logic [2:0] dir);
    logic [7:0] v;
    case (dir)
      3'd0:    v = 8'h80;
      3'd1:    v = 8'h40;
      3'd2:    v = 8'h20;
      3'd3:    v = 8'h10;
      3'd4:    v = 8'hA0;
      3'd5:    v = 8'h90;
      3'd6:    v = 8'h60;
      default: v = 8'h50;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ptz_dome_command_framer_unit.sv
// PTZ dome command framer top level: config registers, request register,
// frame builder and byte serializer. Depends on ptz_pkg, ptz_frame_build, ptz_serializer.
//
// Usage:
//   s_* channel takes one request per beat: s_tdata[4:0] req_type,
//   s_tdata[12:5] param_value, upper bits zero.
//   m_* channel gives the eight frame bytes in order, one per beat; m_tlast
//   marks the checksum byte.
//   cfg_we/cfg_index/cfg_data write camera_address (0), default pan/tilt
//   speed (1) and default zoom speed (2); other indexes are ignored.
// An accepted request is held in the request register, then loaded into the
//   serializer's frame register, which puts its first byte on m_tdata.
// The serializer emits the eight frame bytes one per beat while m_tready is high;
//   the next request waits in the request register and loads on the last
//   byte's beat, so frames follow back to back.
// Clear-preset and unused codes are taken and dropped, no output.
// Reset (rst, synchronous) empties both stages and restores the register
//   defaults: address 1, both speeds 50.
// When the receiver stalls, the current byte holds, and one further request
//   is buffered before s_tready drops.
`default_nettype none

module ptz_dome_command_framer_unit
  import ptz_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // [4:0] req_type, [12:5] param_value
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // [7:0] frame_byte
  output logic                      m_tlast,   // frame_last
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t             cfg;
  logic             in_valid;
  logic [REQ_W-1:0] in_req;
  logic [7:0]       in_param;
  logic             in_pop;
  frame_t           frame;
  logic             frame_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_address <= RST_CAMERA_ADDRESS;
      cfg.default_pt     <= RST_DEFAULT_PT;
      cfg.default_zoom   <= RST_DEFAULT_ZOOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_ADDRESS: cfg.camera_address <= cfg_data;
        CFG_DEFAULT_PT:     cfg.default_pt     <= cfg_data;
        CFG_DEFAULT_ZOOM:   cfg.default_zoom   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request register: drop codes without a frame, otherwise wait for the serializer
  assign in_pop   = in_valid && (!frame.emit || frame_ready);
  assign s_tready = !in_valid || in_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req   <= s_tdata[REQ_W-1:0];
      in_param <= s_tdata[REQ_W+7:REQ_W];
    end
  end

  ptz_frame_build u_build (
    .req_type    (in_req),
    .param_value (in_param),
    .cfg         (cfg),
    .frame       (frame)
  );

  ptz_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (in_valid && frame.emit),
    .frame_ready (frame_ready),
    .frame_bytes (frame.bytes),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/ptz_frame_build.sv
// Combinational frame builder: request, parameter and settings to eight frame bytes.
// Depends on ptz_pkg.
`default_nettype none

module ptz_frame_build
  import ptz_pkg::*;
(
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic [7:0]       param_value,
  input  wire cfg_t             cfg,
  output frame_t                frame
);

  logic [7:0] pt_setting;
  logic [7:0] zm_setting;
  logic [7:0] sp_move;
  logic [7:0] sp_preset;
  logic [2:0] zl;
  logic [7:0] sum;

  // Pick the speed setting and look up the table entries
  always_comb begin
    pt_setting = (param_value != 8'd0) ? param_value : cfg.default_pt;
    zm_setting = (param_value != 8'd0) ? param_value : cfg.default_zoom;
    sp_move    = pt_speed(speed_index(pt_setting));
    sp_preset  = pt_speed(speed_index(cfg.default_pt));
    zl         = zoom_level(speed_index(zm_setting));
  end

  // Fill the command and data bytes
  always_comb begin
    frame.emit     = 1'b1;
    frame.bytes    = '0;
    frame.bytes[0] = START_CODE;
    frame.bytes[1] = DEVICE_ID;
    frame.bytes[2] = cfg.camera_address;
    unique case (req_type) inside
      [REQ_PAN_LEFT:REQ_RIGHT_DOWN]: begin
        frame.bytes[4] = pt_dir_code(req_type[2:0]);
        if (req_type == REQ_PAN_LEFT || req_type == REQ_PAN_RIGHT) begin
          frame.bytes[5] = sp_move;
        end else if (req_type == REQ_TILT_UP || req_type == REQ_TILT_DOWN) begin
          frame.bytes[6] = sp_move;
        end else begin
          frame.bytes[5] = sp_move;
          frame.bytes[6] = sp_move;
        end
      end
      REQ_ZOOM_WIDE, REQ_ZOOM_TELE: begin
        frame.bytes[4] = (req_type == REQ_ZOOM_WIDE) ? CMD_ZOOM_WIDE : CMD_ZOOM_TELE;
        frame.bytes[5] = {7'd0, (zl == 3'd2 || zl == 3'd3 || zl == 3'd4)};
        frame.bytes[6] = {7'd0, (zl == 3'd1 || zl == 3'd4)};
      end
      REQ_IRIS_OPEN:  frame.bytes[3] = CMD_IRIS_OPEN;
      REQ_IRIS_CLOSE: frame.bytes[3] = CMD_IRIS_CLOSE;
      REQ_FOCUS_NEAR: frame.bytes[4] = CMD_FOCUS_NEAR;
      REQ_FOCUS_FAR:  frame.bytes[4] = CMD_FOCUS_FAR;
      REQ_STOP: begin
      end
      REQ_SET_PRESET: begin
        frame.bytes[3] = CMD_SET_PRESET;
        frame.bytes[4] = param_value;
        frame.bytes[5] = sp_preset;
        frame.bytes[6] = PRESET_MARK;
      end
      REQ_GOTO_PRESET: begin
        frame.bytes[3] = CMD_GOTO_PRESET;
        frame.bytes[4] = param_value;
      end
      // clear preset and unused codes produce no frame
      default: frame.emit = 1'b0;
    endcase

    // 8-bit running sum of bytes 0..6
    sum = 8'd0;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      sum = sum + frame.bytes[i];
    end
    frame.bytes[FRAME_LEN-1] = sum;
  end

endmodule

`default_nettype wire

FILE: rtl/ptz_serializer.sv
// Frame register and byte counter that stream one frame out a byte per beat.
// Depends on ptz_pkg.
`default_nettype none

module ptz_serializer
  import ptz_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         frame_valid,
  output logic              frame_ready,
  input  wire frame_bytes_t frame_bytes,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  frame_bytes_t     bytes;
  logic             last_beat;

  assign last_beat   = busy && m_tready && (cnt == LAST_BYTE);
  assign frame_ready = !busy || last_beat;

  // Control: load a frame, advance on each beat, go idle after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (frame_valid && frame_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (last_beat) begin
      busy <= 1'b0;
    end else if (busy && m_tready) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Payload: hold the frame bytes until the next load
  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      bytes <= frame_bytes;
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = bytes[cnt];
  assign m_tlast  = (cnt == LAST_BYTE);

endmodule

`default_nettype wire

FILE: rtl/ptz_checker.sv
// Port-level checker for the framer output stream, bound to the top level.
// Depends on ptz_pkg and ptz_dome_command_framer_unit.
`default_nettype none

module ptz_checker
  import ptz_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  logic [CNT_W-1:0] beat_cnt;
  logic [7:0]       run_sum;
  logic             out_beat;

  assign out_beat = m_tvalid && m_tready;

  // Track position in the frame and the running byte sum
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
      run_sum  <= 8'd0;
    end else if (out_beat) begin
      if (m_tlast) begin
        beat_cnt <= '0;
        run_sum  <= 8'd0;
      end else begin
        beat_cnt <= beat_cnt + 1'b1;
        run_sum  <= run_sum + m_tdata;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beat_cnt == '0 |-> m_tdata == START_CODE)
    else $error("frame does not open with the start code");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (beat_cnt == LAST_BYTE))
    else $error("last flag not on the eighth byte");

  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == run_sum)
    else $error("checksum byte mismatch");

endmodule

bind ptz_dome_command_framer_unit ptz_checker u_ptz_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/ptz_frame_checker.sv
// Frame checker for the PTZ dome command framer: predicts the eight-byte frames
// from each request beat and compares them with the output stream.
// Depends on ptz_pkg for request codes, command bytes and register indexes.
module ptz_frame_checker
  import ptz_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [15:0]          s_tdata,   // [4:0] req_type, [12:5] param_value
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [7:0]           m_tdata,   // [7:0] frame_byte
  input  wire logic                 m_tlast,   // frame_last
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output int                        fail_count,
  output int                        bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Speed lookups, entry 0 in the lowest slot
  localparam logic [9:0][7:0] PT_STEP = {8'h7F, 8'h6F, 8'h60, 8'h52, 8'h44,
                                         8'h38, 8'h2C, 8'h20, 8'h18, 8'h0C};
  localparam logic [9:0][2:0] ZOOM_STEP = {3'd4, 3'd4, 3'd3, 3'd3, 3'd2,
                                           3'd2, 3'd2, 3'd1, 3'd1, 3'd0};
  // Pan/tilt direction byte per move code 0..7
  localparam logic [7:0][7:0] DIR_BYTE = {8'h50, 8'h60, 8'h90, 8'hA0,
                                          8'h10, 8'h20, 8'h40, 8'h80};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t due_bytes [$];
  frame_beat_t want;
  logic [7:0]  cam_addr;
  logic [7:0]  pt_default;
  logic [7:0]  zoom_default;
  int          failures = 0;

  // Setting/10 - 1, clamped to the table range
  function automatic int unsigned table_slot(input logic [7:0] setting);
    int unsigned tens;
    tens = setting / 10;
    if (tens == 0) return 0;
    return (tens - 1 > 9) ? 9 : tens - 1;
  endfunction

  // Build the frame a request yields and queue its bytes
  function automatic void queue_frame(input logic [REQ_W-1:0] req, input logic [7:0] param);
    logic [7:0] f [FRAME_LEN];
    logic [7:0] sp;
    logic [2:0] zl;
    logic [7:0] sum;
    if (req == REQ_CLEAR_PRESET || req > REQ_GOTO_PRESET) return;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'h00;
    f[0] = START_CODE;
    f[1] = DEVICE_ID;
    f[2] = cam_addr;
    if (req <= REQ_RIGHT_DOWN) begin
      sp = PT_STEP[table_slot(param != 8'd0 ? param : pt_default)];
      f[4] = DIR_BYTE[req[2:0]];
      case (req)
        REQ_PAN_LEFT, REQ_PAN_RIGHT: f[5] = sp;
        REQ_TILT_UP, REQ_TILT_DOWN:  f[6] = sp;
        default: begin
          f[5] = sp;
          f[6] = sp;
        end
      endcase
    end else begin
      case (req)
        REQ_ZOOM_WIDE, REQ_ZOOM_TELE: begin
          zl = ZOOM_STEP[table_slot(param != 8'd0 ? param : zoom_default)];
          f[4] = (req == REQ_ZOOM_WIDE) ? CMD_ZOOM_WIDE : CMD_ZOOM_TELE;
          f[5] = {7'd0, zl >= 3'd2};
          f[6] = {7'd0, zl == 3'd1 || zl == 3'd4};
        end
        REQ_IRIS_OPEN:  f[3] = CMD_IRIS_OPEN;
        REQ_IRIS_CLOSE: f[3] = CMD_IRIS_CLOSE;
        REQ_FOCUS_NEAR: f[4] = CMD_FOCUS_NEAR;
        REQ_FOCUS_FAR:  f[4] = CMD_FOCUS_FAR;
        REQ_SET_PRESET: begin
          f[3] = CMD_SET_PRESET;
          f[4] = param;
          f[5] = PT_STEP[table_slot(pt_default)];
          f[6] = PRESET_MARK;
        end
        REQ_GOTO_PRESET: begin
          f[3] = CMD_GOTO_PRESET;
          f[4] = param;
        end
        default: ;  // stop leaves the command and speed bytes at zero
      endcase
    end
    sum = 8'h00;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + f[i];
    f[FRAME_LEN-1] = sum;
    for (int i = 0; i < FRAME_LEN; i++)
      due_bytes.push_back(frame_beat_t'{f[i], i == FRAME_LEN - 1});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cam_addr     = RST_CAMERA_ADDRESS;
      pt_default   = RST_DEFAULT_PT;
      zoom_default = RST_DEFAULT_ZOOM;
      due_bytes.delete();
    end else begin
      // Compare each output beat with the oldest expected byte
      if (m_tvalid && m_tready) begin
        if (due_bytes.size() == 0) begin
          $error("unexpected beat: frame_byte 0x%02h frame_last %0b", m_tdata, m_tlast);
          failures++;
        end else begin
          want = due_bytes.pop_front();
          if (m_tdata !== want.data) begin
            $error("frame_byte: expected 0x%02h, got 0x%02h", want.data, m_tdata);
            failures++;
          end
          if (m_tlast !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, m_tlast);
            failures++;
          end
        end
      end
      // Predict the frame of each accepted request
      if (s_tvalid && s_tready)
        queue_frame(s_tdata[REQ_W-1:0], s_tdata[REQ_W+7:REQ_W]);
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAMERA_ADDRESS: cam_addr     = cfg_data;
          CFG_DEFAULT_PT:     pt_default   = cfg_data;
          CFG_DEFAULT_ZOOM:   zoom_default = cfg_data;
          default: ;
        endcase
      end
    end
    bytes_pending <= due_bytes.size();
    fail_count    <= failures;
  end

endmodule

FILE: verif/testbench.sv
// Top of the PTZ dome command framer testbench: clock, reset, request and
// register stimulus, output back-pressure and the verdict.
// Depends on ptz_pkg, ptz_dome_command_framer_unit and ptz_frame_checker.
module testbench
  import ptz_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 60;
  localparam int PHASE_REQS = 74;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;
  int                   fail_count;
  int                   bytes_pending;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int hold_req     = 0;
  int hold_seen    = 0;

  ptz_dome_command_framer_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ptz_frame_checker frame_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .bytes_pending(bytes_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until accepted; valid stays high afterward
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [7:0] param);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, param, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_req();
    logic [REQ_W-1:0] req;
    logic [7:0]       param;
    if ($urandom_range(9) == 0) req = REQ_W'($urandom_range(18, 31));
    else req = REQ_W'($urandom_range(0, 17));
    param = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
    send_req(req, param);
  endtask

  // Drop valid and wait until every expected byte is out and the block is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] addr, input logic [7:0] pt,
                             input logic [7:0] zoom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAMERA_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_PT;
    cfg_data  <= pt;
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_ZOOM;
    cfg_data  <= zoom;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every code, speed table edges, defaults, presets, dropped codes
    send_req(REQ_PAN_LEFT, 8'd0);
    send_req(REQ_PAN_RIGHT, 8'd255);
    send_req(REQ_TILT_UP, 8'd1);
    send_req(REQ_TILT_DOWN, 8'd19);
    send_req(REQ_LEFT_UP, 8'd20);
    send_req(REQ_LEFT_DOWN, 8'd99);
    send_req(REQ_RIGHT_UP, 8'd100);
    send_req(REQ_RIGHT_DOWN, 8'd109);
    send_req(REQ_ZOOM_WIDE, 8'd0);
    send_req(REQ_ZOOM_TELE, 8'd10);
    send_req(REQ_ZOOM_WIDE, 8'd30);
    send_req(REQ_ZOOM_TELE, 8'd50);
    send_req(REQ_ZOOM_WIDE, 8'd70);
    send_req(REQ_ZOOM_TELE, 8'd255);
    send_req(REQ_IRIS_OPEN, 8'd0);
    send_req(REQ_IRIS_CLOSE, 8'd255);
    send_req(REQ_FOCUS_NEAR, 8'd7);
    send_req(REQ_FOCUS_FAR, 8'd200);
    send_req(REQ_STOP, 8'd0);
    send_req(REQ_SET_PRESET, 8'd0);
    send_req(REQ_SET_PRESET, 8'd255);
    send_req(REQ_CLEAR_PRESET, 8'd3);
    send_req(REQ_GOTO_PRESET, 8'hAA);
    send_req(REQ_GOTO_PRESET, 8'h55);
    send_req(5'd18, 8'd1);
    send_req(5'd31, 8'd255);
    drain();

    // Random phases, each with its own register setting and idling mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_config(8'h00, 8'd0, 8'd0);
        1: load_config(8'hFF, 8'd255, 8'd255);
        2: load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        default: load_config(8'($urandom_range(255)), 8'd19, 8'd100);
      endcase
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      // Hold off the receiver while requests keep coming, to fill the block
      if (phase == 0) hold_req = hold_req + 1;
      repeat (PHASE_REQS) random_req();
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ptz_pkg.sv
rtl/ptz_frame_build.sv
rtl/ptz_serializer.sv
rtl/ptz_dome_command_framer_unit.sv
rtl/ptz_checker.sv
verif/ptz_frame_checker.sv
verif/testbench.sv
